// ===== rtl/ple_pkg.sv =====
package ple_pkg;

    // Fixed widths of the request and response fields.
    localparam int unsigned OP_W     = 3;
    localparam int unsigned POS_W    = 5;
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned LEN_W    = 5;

    // Default number of entries the list can hold.
    localparam int unsigned CAPACITY_DEF = 16;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 3'd0,
        OP_INSERT = 3'd1,
        OP_POP    = 3'd2,
        OP_REMOVE = 3'd3,
        OP_PEEK   = 3'd4,
        OP_READ   = 3'd5,
        OP_CLEAR  = 3'd6
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    // What every cell of the row does in a given cycle.
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_REMOVE = 2'd2
    } cell_act_t;

    // Command broadcast to the row of cells.
    typedef struct packed {
        cell_act_t           act;
        logic [DATA_W-1:0]   ins_value;
    } cell_cmd_t;

endpackage

// ===== rtl/ple_req_if.sv =====
interface ple_req_if
    import ple_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          operation;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output operation, output position, output value,
                    input ready);
    modport sink   (input valid, input operation, input position, input value,
                    output ready);
endinterface

// ===== rtl/ple_rsp_if.sv =====
interface ple_rsp_if
    import ple_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] read_value;
    logic [LEN_W-1:0]         list_length;

    modport source (output valid, output status, output read_value, output list_length,
                    input ready);
    modport sink   (input valid, input status, input read_value, input list_length,
                    output ready);
endinterface

// ===== rtl/ple_cell.sv =====
module ple_cell
    import ple_pkg::*;
#(
    parameter int unsigned IDX_W = 4,
    parameter int unsigned INDEX = 0
)
(
    input  logic              clk,
    input  cell_cmd_t         cmd,
    input  logic [IDX_W-1:0]  idx,
    input  logic [DATA_W-1:0] left_data,
    input  logic [DATA_W-1:0] right_data,
    output logic [DATA_W-1:0] data
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    // Insert opens a gap at idx by taking the left neighbor's entry; remove
    // closes the gap at idx by taking the right neighbor's entry.
    always_comb
    begin
        data_next = data_reg;
        unique case (cmd.act)
            CELL_INSERT:
            begin
                if (MY_IDX == idx)
                begin
                    data_next = cmd.ins_value;
                end
                else if (MY_IDX > idx)
                begin
                    data_next = left_data;
                end
            end
            CELL_REMOVE:
            begin
                if (MY_IDX >= idx)
                begin
                    data_next = right_data;
                end
            end
            CELL_HOLD:
            begin
                data_next = data_reg;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ===== rtl/positional_list_engine_unit.sv =====
// Bounded ordered list of signed 32-bit entries held in a row of CAPACITY
// cells. Each request beat appends, inserts before a 1-based position, pops
// the last entry, removes the entry at a position, peeks at the last entry,
// reads the entry at a position, or clears the list, and produces exactly one
// response beat with a status, the value read or removed (zero on failure),
// and the list length after the request. Every cell shifts toward or away
// from its neighbor in the same cycle, so one request is accepted per cycle,
// and its response appears in the output register on the next cycle. The
// request side stalls only while a response is waiting and the response
// side is not ready. Operation code 7 is ignored and answered with an ok
// status. Entries have no reset; only entries below the current length are
// ever returned.
module positional_list_engine_unit
    import ple_pkg::*;
#(
    parameter int unsigned CAPACITY = CAPACITY_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    ple_req_if.sink   req,
    ple_rsp_if.source rsp
);

    // Count must reach CAPACITY itself; a cell index only needs CAPACITY-1.
    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
    localparam int unsigned IDX_W = $clog2(CAPACITY);
    // Width in which the request position and the count are compared.
    localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                rsp_valid_reg;
    status_t             status_reg;
    logic [DATA_W-1:0]   read_value_reg;
    logic [LEN_W-1:0]    length_reg;

    logic                fire;
    op_t                 op;
    logic [CMP_W-1:0]    pos_ext;
    logic [CMP_W-1:0]    cnt_ext;
    logic [CMP_W-1:0]    pos_m1;
    logic [CNT_W-1:0]    cnt_m1;
    logic                pos_ok;
    logic                empty;
    logic                full;
    logic [IDX_W-1:0]    pos_idx;
    logic [IDX_W-1:0]    last_idx;
    logic [IDX_W-1:0]    cnt_idx;
    logic [IDX_W-1:0]    rd_idx;
    logic [DATA_W-1:0]   cell_rd;

    status_t             status_next;
    logic [DATA_W-1:0]   read_value_next;
    cell_act_t           act_d;
    logic [IDX_W-1:0]    idx_d;
    cell_cmd_t           cmd;

    logic [DATA_W-1:0]   cell_data [CAPACITY];

    // A new request is taken whenever the output register is empty or is
    // being emptied in the same cycle.
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign fire      = req.valid && req.ready;
    assign op        = op_t'(req.operation);

    assign pos_ext  = CMP_W'(req.position);
    assign cnt_ext  = CMP_W'(count_reg);
    assign pos_m1   = pos_ext - CMP_W'(1);
    assign cnt_m1   = count_reg - CNT_W'(1);
    assign pos_ok   = (pos_ext != '0) && (pos_ext <= cnt_ext);
    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign pos_idx  = pos_m1[IDX_W-1:0];
    assign last_idx = cnt_m1[IDX_W-1:0];
    assign cnt_idx  = count_reg[IDX_W-1:0];

    // Single read port into the row: the tail for pop and peek, otherwise
    // the requested position.
    assign rd_idx  = ((op == OP_POP) || (op == OP_PEEK)) ? last_idx : pos_idx;
    assign cell_rd = cell_data[rd_idx];

    // Request decode. Checks follow the list semantics: insert checks the
    // position before fullness, remove checks emptiness before the position,
    // and a read from an empty list is simply out of range.
    always_comb
    begin
        status_next     = ST_OK;
        read_value_next = '0;
        count_next      = count_reg;
        act_d           = CELL_HOLD;
        idx_d           = pos_idx;
        unique case (op)
            OP_APPEND:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    act_d      = CELL_INSERT;
                    idx_d      = cnt_idx;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_INSERT:
            begin
                if (!pos_ok)
                begin
                    status_next = ST_RANGE;
                end
                else if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    act_d      = CELL_INSERT;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_POP:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    read_value_next = cell_rd;
                    count_next      = cnt_m1;
                end
            end
            OP_REMOVE:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else if (!pos_ok)
                begin
                    status_next = ST_RANGE;
                end
                else
                begin
                    read_value_next = cell_rd;
                    act_d           = CELL_REMOVE;
                    count_next      = cnt_m1;
                end
            end
            OP_PEEK:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    read_value_next = cell_rd;
                end
            end
            OP_READ:
            begin
                if (!pos_ok)
                begin
                    status_next = ST_RANGE;
                end
                else
                begin
                    read_value_next = cell_rd;
                end
            end
            OP_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    // The row only moves on an accepted request beat.
    assign cmd.act       = fire ? act_d : CELL_HOLD;
    assign cmd.ins_value = req.value;

    // Row of cells. The first cell has no left neighbor and the last has no
    // right neighbor; those inputs are never selected for a live entry.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DATA_W-1:0] left_data;
        logic [DATA_W-1:0] right_data;

        if (i == 0)
        begin : g_first
            assign left_data = req.value;
        end
        else
        begin : g_inner_l
            assign left_data = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_data = cell_data[i];
        end
        else
        begin : g_inner_r
            assign right_data = cell_data[i+1];
        end

        ple_cell #(
            .IDX_W (IDX_W),
            .INDEX (i)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .idx        (idx_d),
            .left_data  (left_data),
            .right_data (right_data),
            .data       (cell_data[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Response payload needs no reset; it is qualified by the valid flag.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            status_reg     <= status_next;
            read_value_reg <= read_value_next;
            length_reg     <= LEN_W'(count_next);
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.read_value  = read_value_reg;
    assign rsp.list_length = length_reg;

`ifndef SYNTH
    // The list never grows past its capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("list count exceeds capacity");

    // Every accepted request leaves a response in the output register.
    a_fire_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> rsp_valid_reg)
        else $error("accepted request produced no response");

    // A failed request never returns data.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && (status_reg != ST_OK)) |-> (read_value_reg == '0))
        else $error("failed request returned nonzero data");

    // Appending to a full list reports full and leaves the count alone.
    a_full_append: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (op == OP_APPEND) && full) |=>
        ((status_reg == ST_FULL) && (count_reg == $past(count_reg))))
        else $error("append to full list misbehaved");
`endif

endmodule

// ===== dv/testbench.sv =====
module testbench
    import ple_pkg::*;
;

    localparam int unsigned          LIST_DEPTH = CAPACITY_DEF;
    localparam logic [OP_W-1:0]      OP_UNUSED  = 3'd7;

    typedef struct packed {
        status_t                  status;
        logic signed [DATA_W-1:0] value;
        logic [LEN_W-1:0]         length;
    } list_answer_t;

    // Shadow copy of the list; predicts the answer to every accepted request.
    class list_shadow;
        logic signed [DATA_W-1:0] slots [LIST_DEPTH];
        int unsigned              fill;
        list_answer_t             pending_answers [$];
        int unsigned              mismatches;

        function new();
            fill       = 0;
            mismatches = 0;
        endfunction

        function void note_request(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                   logic signed [DATA_W-1:0] val);
            list_answer_t ans;
            int unsigned  i;
            bit           pos_ok;
            ans.status = ST_OK;
            ans.value  = '0;
            pos_ok     = (pos >= 1) && (pos <= fill);
            case (op)
                OP_APPEND:
                    if (fill >= LIST_DEPTH)
                        ans.status = ST_FULL;
                    else
                    begin
                        slots[fill] = val;
                        fill++;
                    end
                OP_INSERT:
                    if (!pos_ok)
                        ans.status = ST_RANGE;
                    else if (fill >= LIST_DEPTH)
                        ans.status = ST_FULL;
                    else
                    begin
                        for (i = fill; i >= pos; i--)
                            slots[i] = slots[i - 1];
                        slots[pos - 1] = val;
                        fill++;
                    end
                OP_POP:
                    if (fill == 0)
                        ans.status = ST_EMPTY;
                    else
                    begin
                        ans.value = slots[fill - 1];
                        fill--;
                    end
                OP_REMOVE:
                    if (fill == 0)
                        ans.status = ST_EMPTY;
                    else if (!pos_ok)
                        ans.status = ST_RANGE;
                    else
                    begin
                        ans.value = slots[pos - 1];
                        for (i = pos - 1; i + 1 < fill; i++)
                            slots[i] = slots[i + 1];
                        fill--;
                    end
                OP_PEEK:
                    if (fill == 0)
                        ans.status = ST_EMPTY;
                    else
                        ans.value = slots[fill - 1];
                OP_READ:
                    if (!pos_ok)
                        ans.status = ST_RANGE;
                    else
                        ans.value = slots[pos - 1];
                OP_CLEAR:
                    fill = 0;
                default:
                    ;
            endcase
            ans.length = LEN_W'(fill);
            pending_answers.push_back(ans);
        endfunction

        function void check_answer(logic [STATUS_W-1:0] status,
                                   logic signed [DATA_W-1:0] value,
                                   logic [LEN_W-1:0] length);
            list_answer_t want;
            if (pending_answers.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response beat: status %0d value %0d length %0d",
                             status, value, length);
                return;
            end
            want = pending_answers.pop_front();
            if (want.status !== status || want.value !== value || want.length !== length)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected status %0d value %0d length %0d, got %0d %0d %0d",
                             want.status, want.value, want.length, status, value, length);
            end
        endfunction

        function int unsigned outstanding();
            return pending_answers.size();
        endfunction
    endclass

    localparam int unsigned CYCLE_LIMIT = 200_000;
    localparam int unsigned RANDOM_ITEMS = 950;

    // Flavors of random traffic. Grow and shrink bursts push the list to its
    // full and empty ends; noise covers every code and position the fields allow.
    typedef enum {MIX_GROW, MIX_SHRINK, MIX_BALANCED, MIX_NOISE} traffic_mix_t;

    logic        clk;
    logic        rst_n = 1'b0;
    bit          steady;
    int unsigned cycles;

    ple_req_if req_ch();
    ple_rsp_if rsp_ch();

    list_shadow shadow = new();

    positional_list_engine_unit #(.CAPACITY(LIST_DEPTH)) DUT
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs on either handshake.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Both monitors sample at the rising edge; the inputs only move at the
    // falling edge, so every sampled value has long settled.
    always @(posedge clk)
    begin
        if (rst_n && req_ch.valid && req_ch.ready)
            shadow.note_request(req_ch.operation, req_ch.position, req_ch.value);
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            shadow.check_answer(rsp_ch.status, rsp_ch.read_value, rsp_ch.list_length);
    end

    // Wait drawn before each beat on either side. While steady is set, both
    // sides run back to back so the one-per-cycle rate gets exercised too.
    function automatic int unsigned pick_wait();
        return steady ? 0 : $urandom_range(0, 8);
    endfunction

    // Mostly random words, with the sign and all-ones extremes mixed in.
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 15))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Positions usually land inside the list; the rest span the whole field.
    function automatic logic [POS_W-1:0] pick_position(int unsigned fill);
        if (fill > 0 && $urandom_range(0, 7) != 0)
            return POS_W'($urandom_range(1, fill));
        return POS_W'($urandom_range(0, 31));
    endfunction

    // Present one request beat and hold it until the block takes it. A zero
    // wait keeps valid high straight into the next beat.
    task automatic send_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                                input logic signed [DATA_W-1:0] val);
        int unsigned gap;
        gap = pick_wait();
        if (gap > 0)
        begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid     = 1'b1;
        req_ch.operation = op;
        req_ch.position  = pos;
        req_ch.value     = val;
        do @(posedge clk); while (!req_ch.ready);
        @(negedge clk);
    endtask

    task automatic send_random(input traffic_mix_t mix);
        logic [OP_W-1:0] op;
        int unsigned     roll;
        int unsigned     fill;
        fill = shadow.fill;
        roll = $urandom_range(0, 39);
        case (mix)
            MIX_GROW:
                op = (roll < 20) ? OP_APPEND : (roll < 32) ? OP_INSERT :
                     (roll < 36) ? OP_READ : OP_PEEK;
            MIX_SHRINK:
                op = (roll < 18) ? OP_POP : (roll < 34) ? OP_REMOVE :
                     (roll < 38) ? OP_READ : OP_PEEK;
            MIX_BALANCED:
                op = (roll < 7) ? OP_APPEND : (roll < 14) ? OP_INSERT :
                     (roll < 20) ? OP_POP : (roll < 27) ? OP_REMOVE :
                     (roll < 31) ? OP_PEEK : (roll < 39) ? OP_READ : OP_CLEAR;
            default:
                op = OP_W'($urandom_range(0, 7));
        endcase
        if (mix == MIX_NOISE)
            send_request(op, POS_W'($urandom_range(0, 31)), $urandom);
        else
            send_request(op, pick_position(fill), pick_value());
    endtask

    // Response side: before every beat it holds ready low for a drawn number
    // of cycles, then waits with ready high until a beat is taken.
    initial
    begin
        int unsigned stall;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = pick_wait();
            if (stall > 0)
            begin
                rsp_ch.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ch.ready = 1'b1;
            do @(posedge clk); while (!rsp_ch.valid);
            @(negedge clk);
        end
    end

    initial
    begin
        int unsigned  items_sent;
        int unsigned  burst;
        int unsigned  k;
        traffic_mix_t mix;

        req_ch.valid     = 1'b0;
        req_ch.operation = OP_APPEND;
        req_ch.position  = '0;
        req_ch.value     = '0;
        steady           = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Empty list: pop, peek and remove report empty (remove even with a
        // bad position), read and insert report a bad position.
        send_request(OP_POP, 5'd1, 32'sd0);
        send_request(OP_PEEK, 5'd0, 32'sd0);
        send_request(OP_REMOVE, 5'd0, 32'sd0);
        send_request(OP_REMOVE, 5'd1, 32'sd0);
        send_request(OP_READ, 5'd1, 32'sd0);
        send_request(OP_INSERT, 5'd1, 32'sd5);

        // Build a short list from the value extremes and probe its edges.
        send_request(OP_APPEND, 5'd0, 32'sh7FFF_FFFF);
        send_request(OP_APPEND, 5'd31, 32'sh8000_0000);
        send_request(OP_INSERT, 5'd1, 32'shFFFF_FFFF);
        send_request(OP_INSERT, 5'd3, 32'sh5A5A_A5A5);
        send_request(OP_INSERT, 5'd0, 32'sd1);
        send_request(OP_INSERT, 5'd5, 32'sd1);
        send_request(OP_READ, 5'd1, 32'sd0);
        send_request(OP_READ, 5'd4, 32'sd0);
        send_request(OP_READ, 5'd0, 32'sd0);
        send_request(OP_READ, 5'd31, 32'sd0);
        send_request(OP_REMOVE, 5'd2, 32'sd0);
        send_request(OP_REMOVE, 5'd31, 32'sd0);
        send_request(OP_UNUSED, 5'd31, 32'shFFFF_FFFF);
        send_request(OP_PEEK, 5'd0, 32'sd0);
        send_request(OP_POP, 5'd0, 32'sd0);
        send_request(OP_CLEAR, 5'd0, 32'sd0);

        // Fill the list to capacity, then show that append and insert at a
        // valid position report full while a position past the end still
        // reports out of range first.
        for (k = 0; k < LIST_DEPTH; k++)
            send_request(OP_APPEND, 5'd0, $urandom);
        send_request(OP_APPEND, 5'd0, 32'sd7);
        send_request(OP_INSERT, 5'd16, 32'sd7);
        send_request(OP_INSERT, 5'd17, 32'sd7);
        send_request(OP_READ, 5'd16, 32'sd0);
        send_request(OP_REMOVE, 5'd16, 32'sd0);

        // Random traffic in bursts, each with its own mix and idling flavor.
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            k      = $urandom_range(0, 9);
            mix    = (k < 3) ? MIX_GROW : (k < 5) ? MIX_SHRINK :
                     (k < 9) ? MIX_BALANCED : MIX_NOISE;
            steady = ($urandom_range(0, 3) == 0);
            burst  = $urandom_range(10, 40);
            repeat (burst)
            begin
                send_random(mix);
                items_sent++;
            end
        end
        steady       = 1'b0;
        req_ch.valid = 1'b0;

        // Drain: every expected answer must arrive, and quiet cycles after that
        // catch any stray beat.
        while (shadow.outstanding() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        if (shadow.mismatches == 0 && shadow.outstanding() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
